// File: rtl/mpg_pkg.sv
// Package for the motor power guard: widths, codes, item/result/state/config
// structs and the state encoding helper. No dependencies.
package mpg_pkg;

  localparam int POWER_BITS    = 16;
  localparam int SENSE_BITS    = 16;
  localparam int MAG_BITS      = 15;
  localparam int LIMIT_BITS    = 16;
  localparam int ELAPSED_BITS  = 16;
  localparam int COUNT_BITS    = 32;
  localparam int CMD_BITS      = 3;
  localparam int MODE_BITS     = 2;
  localparam int CAUSE_BITS    = 2;
  localparam int MASK_BITS     = 2;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 16;

  // Signed working width for clamp, dead zone and negation: room for the
  // field, the zero-extended magnitudes and one negation.
  localparam int CALC_BITS = ((POWER_BITS > MAG_BITS + 1) ? POWER_BITS : MAG_BITS + 1) + 2;
  localparam int CMP_BITS  = (SENSE_BITS > LIMIT_BITS) ? SENSE_BITS : LIMIT_BITS;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_SET_POWER = 3'd0,
    CMD_PROTECT   = 3'd1,
    CMD_TICK      = 3'd2,
    CMD_CLEAR     = 3'd3,
    CMD_FORCE     = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_RUN  = 3'b010,
    MODE_ERR  = 3'b100
  } mode_t;

  localparam logic [MODE_BITS-1:0]  MS_IDLE = 2'd0;
  localparam logic [MODE_BITS-1:0]  MS_RUN  = 2'd1;
  localparam logic [MODE_BITS-1:0]  MS_ERR  = 2'd2;

  localparam logic [CAUSE_BITS-1:0] CAUSE_NONE        = 2'd0;
  localparam logic [CAUSE_BITS-1:0] CAUSE_OVERCURRENT = 2'd1;
  localparam logic [CAUSE_BITS-1:0] CAUSE_OVERHEAT    = 2'd2;

  localparam logic DIR_FORWARD  = 1'b0;
  localparam logic DIR_BACKWARD = 1'b1;

  localparam logic [CFG_ADDR_BITS-1:0] REG_POWER_CEIL   = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_DEAD_BAND    = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_INVERT_DIR   = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_CURRENT_LIM  = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_TEMP_LIM     = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_PROTECT_MASK = 3'd5;

  localparam logic [MAG_BITS-1:0]   RST_POWER_CEIL   = 15'd32767;
  localparam logic [MAG_BITS-1:0]   RST_DEAD_BAND    = 15'd0;
  localparam logic [LIMIT_BITS-1:0] RST_CURRENT_LIM  = 16'd3000;
  localparam logic [LIMIT_BITS-1:0] RST_TEMP_LIM     = 16'd80;
  localparam logic [MASK_BITS-1:0]  RST_PROTECT_MASK = 2'd3;

  typedef struct packed {
    logic [CMD_BITS-1:0]          cmd;
    logic signed [POWER_BITS-1:0] power_cmd;
    logic [SENSE_BITS-1:0]        current_sample;
    logic [SENSE_BITS-1:0]        temperature_sample;
    logic [ELAPSED_BITS-1:0]      elapsed_ms;
    logic [MODE_BITS-1:0]         forced_state;
  } item_t;

  typedef struct packed {
    logic [MAG_BITS-1:0]   power_ceil;
    logic [MAG_BITS-1:0]   dead_band;
    logic                  invert_dir;
    logic [LIMIT_BITS-1:0] current_limit;
    logic [LIMIT_BITS-1:0] temperature_limit;
    logic [MASK_BITS-1:0]  protect_mask;
  } cfg_t;

  typedef struct packed {
    mode_t                        mode;
    logic                         dir;
    logic signed [POWER_BITS-1:0] power;
    logic [CAUSE_BITS-1:0]        cause;
    logic [COUNT_BITS-1:0]        run_time;
    logic [COUNT_BITS-1:0]        starts;
    logic [COUNT_BITS-1:0]        trips;
  } state_t;

  typedef struct packed {
    logic                         status;
    logic [MODE_BITS-1:0]         motor_state;
    logic                         direction;
    logic signed [POWER_BITS-1:0] applied_power;
    logic [CAUSE_BITS-1:0]        error_cause;
    logic [COUNT_BITS-1:0]        run_time;
    logic [COUNT_BITS-1:0]        start_count;
    logic [COUNT_BITS-1:0]        trip_count;
  } result_t;

  function automatic logic [MODE_BITS-1:0] mode_code(mode_t m);
    logic [MODE_BITS-1:0] c;
    case (m)
      MODE_RUN: c = MS_RUN;
      MODE_ERR: c = MS_ERR;
      default:  c = MS_IDLE;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/mpg_if.sv
// Valid/ready channel interfaces for the motor power guard items and results.
// Depends on mpg_pkg.
interface mpg_in_if;
  import mpg_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [CMD_BITS-1:0]          cmd;
  logic signed [POWER_BITS-1:0] power_cmd;
  logic [SENSE_BITS-1:0]        current_sample;
  logic [SENSE_BITS-1:0]        temperature_sample;
  logic [ELAPSED_BITS-1:0]      elapsed_ms;
  logic [MODE_BITS-1:0]         forced_state;

  modport source (output valid, cmd, power_cmd, current_sample, temperature_sample,
                  elapsed_ms, forced_state, input ready);
  modport sink   (input valid, cmd, power_cmd, current_sample, temperature_sample,
                  elapsed_ms, forced_state, output ready);
endinterface

interface mpg_out_if;
  import mpg_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [MODE_BITS-1:0]         motor_state;
  logic                         direction;
  logic signed [POWER_BITS-1:0] applied_power;
  logic [CAUSE_BITS-1:0]        error_cause;
  logic [COUNT_BITS-1:0]        run_time;
  logic [COUNT_BITS-1:0]        start_count;
  logic [COUNT_BITS-1:0]        trip_count;

  modport source (output valid, status, motor_state, direction, applied_power, error_cause,
                  run_time, start_count, trip_count, input ready);
  modport sink   (input valid, status, motor_state, direction, applied_power, error_cause,
                  run_time, start_count, trip_count, output ready);
endinterface

// File: rtl/mpg_cfg.sv
// Configuration register file of the motor power guard (write only).
// Depends on mpg_pkg.
module mpg_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               we,
  input  logic [mpg_pkg::CFG_ADDR_BITS-1:0]  addr,
  input  logic [mpg_pkg::CFG_DATA_BITS-1:0]  wdata,
  output mpg_pkg::cfg_t                      cfg
);
  import mpg_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.power_ceil        <= RST_POWER_CEIL;
      cfg_r.dead_band         <= RST_DEAD_BAND;
      cfg_r.invert_dir        <= 1'b0;
      cfg_r.current_limit     <= RST_CURRENT_LIM;
      cfg_r.temperature_limit <= RST_TEMP_LIM;
      cfg_r.protect_mask      <= RST_PROTECT_MASK;
    end else if (we) begin
      case (addr)
        REG_POWER_CEIL:   cfg_r.power_ceil        <= wdata[MAG_BITS-1:0];
        REG_DEAD_BAND:    cfg_r.dead_band         <= wdata[MAG_BITS-1:0];
        REG_INVERT_DIR:   cfg_r.invert_dir        <= wdata[0];
        REG_CURRENT_LIM:  cfg_r.current_limit     <= wdata[LIMIT_BITS-1:0];
        REG_TEMP_LIM:     cfg_r.temperature_limit <= wdata[LIMIT_BITS-1:0];
        REG_PROTECT_MASK: cfg_r.protect_mask      <= wdata[MASK_BITS-1:0];
        default:          ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/mpg_step.sv
// Combinational command step: next guard state and the result for one item.
// Depends on mpg_pkg.
module mpg_step (
  input  mpg_pkg::item_t   item,
  input  mpg_pkg::cfg_t    cfg,
  input  mpg_pkg::state_t  st,
  output mpg_pkg::state_t  st_nxt,
  output mpg_pkg::result_t res
);
  import mpg_pkg::*;

  logic signed [CALC_BITS-1:0] p_in;
  logic signed [CALC_BITS-1:0] mx;
  logic signed [CALC_BITS-1:0] mn;
  logic signed [CALC_BITS-1:0] top;
  logic signed [CALC_BITS-1:0] p_clamp;
  logic signed [CALC_BITS-1:0] p_dz;
  logic signed [CALC_BITS-1:0] p_inv;
  logic signed [CALC_BITS-1:0] p_out;
  logic [CMP_BITS-1:0]         cur;
  logic [CMP_BITS-1:0]         temp;
  logic [CMP_BITS-1:0]         cur_lim;
  logic [CMP_BITS-1:0]         temp_lim;
  logic                        trip_oc;
  logic                        trip_oh;

  assign p_in = CALC_BITS'(item.power_cmd);
  assign mx   = signed'(CALC_BITS'(cfg.power_ceil));
  assign mn   = signed'(CALC_BITS'(cfg.dead_band));
  assign top  = signed'(CALC_BITS'({(POWER_BITS-1){1'b1}}));

  // clamp, dead zone, optional inversion, then saturate on the positive side
  assign p_clamp = (p_in > mx) ? mx : ((p_in < -mx) ? -mx : p_in);
  assign p_dz    = ((p_clamp > -mn) && (p_clamp < mn)) ? '0 : p_clamp;
  assign p_inv   = cfg.invert_dir ? -p_dz : p_dz;
  assign p_out   = (p_inv > top) ? top : p_inv;

  assign cur      = CMP_BITS'(item.current_sample);
  assign temp     = CMP_BITS'(item.temperature_sample);
  assign cur_lim  = CMP_BITS'(cfg.current_limit);
  assign temp_lim = CMP_BITS'(cfg.temperature_limit);
  assign trip_oc  = cfg.protect_mask[0] && (cur > cur_lim);
  assign trip_oh  = cfg.protect_mask[1] && (temp > temp_lim);

  always_comb begin
    st_nxt     = st;
    res.status = 1'b0;
    case (item.cmd)
      CMD_SET_POWER: begin
        st_nxt.power = p_out[POWER_BITS-1:0];
        if (p_out > 0) begin
          st_nxt.dir = DIR_FORWARD;
        end else if (p_out < 0) begin
          st_nxt.dir = DIR_BACKWARD;
        end
        if (p_out != 0) begin
          if (st.mode != MODE_RUN) begin
            st_nxt.starts = st.starts + COUNT_BITS'(1);
          end
          st_nxt.mode = MODE_RUN;
        end else begin
          st_nxt.mode = MODE_IDLE;
        end
      end
      CMD_PROTECT: begin
        if (trip_oc || trip_oh) begin
          st_nxt.cause = trip_oc ? CAUSE_OVERCURRENT : CAUSE_OVERHEAT;
          st_nxt.mode  = MODE_ERR;
          st_nxt.trips = st.trips + COUNT_BITS'(1);
          res.status   = 1'b1;
        end
      end
      CMD_TICK: begin
        if (st.mode == MODE_RUN) begin
          st_nxt.run_time = st.run_time + COUNT_BITS'(item.elapsed_ms);
        end
      end
      CMD_CLEAR: begin
        st_nxt.cause = CAUSE_NONE;
        if (st.mode == MODE_ERR) begin
          st_nxt.mode = MODE_IDLE;
        end
      end
      CMD_FORCE: begin
        case (item.forced_state)
          MS_IDLE: st_nxt.mode = MODE_IDLE;
          MS_RUN:  st_nxt.mode = MODE_RUN;
          MS_ERR:  st_nxt.mode = MODE_ERR;
          default: ;
        endcase
      end
      default: ;
    endcase

    res.motor_state   = mode_code(st_nxt.mode);
    res.direction     = st_nxt.dir;
    res.applied_power = st_nxt.power;
    res.error_cause   = st_nxt.cause;
    res.run_time      = st_nxt.run_time;
    res.start_count   = st_nxt.starts;
    res.trip_count    = st_nxt.trips;
  end

endmodule

// File: rtl/motor_power_guard.sv
// Motor power guard top level: input item register, command step, state and
// result registers. Depends on mpg_pkg, mpg_if, mpg_cfg and mpg_step.
//
//   port     dir    handshake        carries
//   in_ch    sink   valid/ready      one command item
//   out_ch   source valid/ready      status, state and statistics per item
//   cfg_*    in     cfg_we only      register index and write data
//
// Flow: one item per clock sustained while the output is not stalled; an
//   accepted item moves from the input register through one pass of the step
//   logic into the result register together with the guard state, and the
//   result is presented there until it is taken.
// Reset: synchronous, active low; clears the guard state, the configuration
//   registers and both valid flags.
// Stalls: a held result stalls the input register, which still takes one
//   more item; the input side sees ready drop only when both are full.
module motor_power_guard (
  input  logic                               clk,
  input  logic                               rst_n,
  mpg_in_if.sink                             in_ch,
  mpg_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [mpg_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [mpg_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
  import mpg_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    s1_valid_r;
  logic    s1_valid_nxt;
  logic    out_valid_r;
  logic    out_valid_nxt;
  result_t res_r;
  result_t res_nxt;
  state_t  st_r;
  state_t  st_nxt;
  logic    s1_go;
  logic    in_fire;
  logic    s1_fire;

  mpg_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (cfg_we),
    .addr  (cfg_addr),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  mpg_step u_step (
    .item   (item_r),
    .cfg    (cfg),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  // advance the input register when the result slot is free or draining
  assign s1_go       = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_go;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign s1_fire     = s1_valid_r && s1_go;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_go);
  assign out_valid_nxt = s1_fire || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // capture the item payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.cmd                <= in_ch.cmd;
      item_r.power_cmd          <= in_ch.power_cmd;
      item_r.current_sample     <= in_ch.current_sample;
      item_r.temperature_sample <= in_ch.temperature_sample;
      item_r.elapsed_ms         <= in_ch.elapsed_ms;
      item_r.forced_state       <= in_ch.forced_state;
    end
  end

  // commit guard state when the item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode     <= MODE_IDLE;
      st_r.dir      <= DIR_FORWARD;
      st_r.power    <= '0;
      st_r.cause    <= CAUSE_NONE;
      st_r.run_time <= '0;
      st_r.starts   <= '0;
      st_r.trips    <= '0;
    end else if (s1_fire) begin
      st_r <= st_nxt;
    end
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = res_r.status;
  assign out_ch.motor_state   = res_r.motor_state;
  assign out_ch.direction     = res_r.direction;
  assign out_ch.applied_power = res_r.applied_power;
  assign out_ch.error_cause   = res_r.error_cause;
  assign out_ch.run_time      = res_r.run_time;
  assign out_ch.start_count   = res_r.start_count;
  assign out_ch.trip_count    = res_r.trip_count;

  // a tripping result and a trip count step go together
  a_trip_count: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> ((res_r.status == 1'b1) == (st_r.trips == $past(st_r.trips) + COUNT_BITS'(1))))
    else $error("trip counter out of step with status");

  // a start is counted only on a result that reports running
  a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> ((st_r.starts == $past(st_r.starts)) || (res_r.motor_state == MS_RUN)))
    else $error("start counted without running state");

  // statistics hold while no item is processed
  a_stats_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> ($stable(st_r.trips) && $stable(st_r.starts) && $stable(st_r.run_time)))
    else $error("statistics moved without an item");

  // an empty result register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty result register");

endmodule
